// ===== src/urbc_pkg.sv =====
// ----------------------------------------------------------------------------
// urbc_pkg : shared types and codes for the UART ring buffer controller
// Mode codes, configuration register indexes and the ring status struct.
// ----------------------------------------------------------------------------
package urbc_pkg;

    localparam int unsigned MODE_W    = 3;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned ERR_W     = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_LINE   = 3'd0,
        MODE_PUT    = 3'd1,
        MODE_GET    = 3'd2,
        MODE_FINISH = 3'd3,
        MODE_FLUSH  = 3'd4
    } t_mode;

    localparam logic [CFG_IDX_W-1:0] CFG_RX_NOTIFY_EN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_NOTIFY_EN = 8'd1;

    // Ring status seen by the controller
    typedef struct packed {
        logic full;   // one slot left free: next write position hits read position
        logic empty;
    } t_ring_stat;

endpackage

// ===== src/urbc_ring.sv =====
// ----------------------------------------------------------------------------
// urbc_ring : byte ring queue with one slot kept free
// Write and read pointers, a byte memory with registered read data, flush.
// ----------------------------------------------------------------------------
module urbc_ring #(
    parameter int unsigned DEPTH = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  logic [urbc_pkg::BYTE_W-1:0]       i_push_data,
    input  logic                              i_pop,
    input  logic                              i_flush,
    output urbc_pkg::t_ring_stat              o_stat,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] o_fill,
    output logic [urbc_pkg::BYTE_W-1:0]       o_rd_data
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [urbc_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW-1:0] n_wp, n_rp;
    logic [PW:0]   diff;

    function automatic logic [PW-1:0] step(input logic [PW-1:0] p);
        return (p == LAST) ? '0 : p + PW'(1);
    endfunction

    assign n_wp = step(r_wp);
    assign n_rp = step(r_rp);

    assign o_stat.full  = (n_wp == r_rp);
    assign o_stat.empty = (r_wp == r_rp);

    // fill = (wp - rp) mod DEPTH
    always_comb begin
        diff = {1'b0, r_wp} - {1'b0, r_rp};
        if (r_wp < r_rp) begin
            diff = diff + (PW+1)'(DEPTH);
        end
    end
    assign o_fill = diff[PW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else if (i_flush) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push) begin
                r_wp <= n_wp;
            end
            if (i_pop) begin
                r_rp <= n_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_data;
        end
        if (i_pop) begin
            o_rd_data <= r_mem[r_rp];
        end
    end

endmodule

// ===== src/uart_ring_buffer_controller.sv =====
// ----------------------------------------------------------------------------
// uart_ring_buffer_controller : UART line to software ring queue controller
// Transmit and receive rings, line status event handling, software access.
// ----------------------------------------------------------------------------
// Use:
//   Input channel (i_in_valid / o_in_ready) carries one request word: a line
//   status event or a software put, get, finish or flush, chosen by i_mode.
//   Output channel (o_out_valid / i_out_ready) returns exactly one result
//   word per request. Configuration channel (i_cfg_valid / o_cfg_ready) sets
//   the two notification enables; it is always ready. The user must write it
//   only while no request is in flight; the block itself does not enforce it.
//   Writing the receive enable clears the pending receive notification mark.
// Timing:
//   A request accepted at a clock edge has its result in the output register
//   in the next cycle. Throughput is one request per cycle while the output
//   is not stalled, set by the single ring memory access and pointer update
//   per request. The rings hold DEPTH-1 bytes each.
// Reset:
//   Pointers, flags, error count and enables clear; the ring memories are
//   not cleared, bytes are only read once written.
// Stall:
//   While a result waits on a low i_out_ready, o_in_ready drops and the
//   result, counters and fill levels hold.
// ----------------------------------------------------------------------------
module uart_ring_buffer_controller #(
    parameter int unsigned TX_DEPTH = 256,
    parameter int unsigned RX_DEPTH = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [urbc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic                                 i_cfg_data,
    // request channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [urbc_pkg::MODE_W-1:0]          i_mode,
    input  logic                                 i_rx_ready,
    input  logic                                 i_rx_bad,
    input  logic                                 i_line_overrun,
    input  logic                                 i_tx_slot_free,
    input  logic                                 i_tx_finished,
    input  logic [urbc_pkg::BYTE_W-1:0]          i_line_byte,
    input  logic [urbc_pkg::BYTE_W-1:0]          i_user_byte,
    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_send_valid,
    output logic [urbc_pkg::BYTE_W-1:0]          o_send_byte,
    output logic                                 o_rx_notify,
    output logic                                 o_tx_notify,
    output logic                                 o_put_accepted,
    output logic                                 o_get_valid,
    output logic [urbc_pkg::BYTE_W-1:0]          o_get_byte,
    output logic                                 o_rx_still_pending,
    output logic [urbc_pkg::ERR_W-1:0]           o_error_total,
    output logic [urbc_pkg::BYTE_W-1:0]          o_rx_fill,
    output logic                                 o_tx_idle
);

    localparam int unsigned TX_PW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int unsigned RX_PW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;

    // control state
    logic r_send_enable, n_send_enable;
    logic r_complete_armed, n_complete_armed;
    logic r_tx_busy, n_tx_busy;
    logic r_notify_pending, n_notify_pending;
    logic [urbc_pkg::ERR_W-1:0] r_err, n_err;
    logic r_rx_en, r_tx_en;

    // result register
    logic r_out_valid;
    logic r_send_valid, n_send_valid;
    logic r_rx_notify, n_rx_notify;
    logic r_tx_notify, n_tx_notify;
    logic r_put_acc, n_put_acc;
    logic r_get_valid, n_get_valid;
    logic r_still, n_still;

    // ring control
    logic tx_push, tx_pop, rx_push, rx_pop, flush;
    urbc_pkg::t_ring_stat tx_stat, rx_stat;
    logic [TX_PW-1:0] tx_fill;
    logic [RX_PW-1:0] rx_fill;
    logic [urbc_pkg::BYTE_W-1:0] tx_rd_data, rx_rd_data;

    logic in_fire;
    logic err_rx;
    logic send_try;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;

    urbc_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (tx_push),
        .i_push_data (i_user_byte),
        .i_pop       (tx_pop),
        .i_flush     (flush),
        .o_stat      (tx_stat),
        .o_fill      (tx_fill),
        .o_rd_data   (tx_rd_data)
    );

    urbc_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (rx_push),
        .i_push_data (i_line_byte),
        .i_pop       (rx_pop),
        .i_flush     (flush),
        .o_stat      (rx_stat),
        .o_fill      (rx_fill),
        .o_rd_data   (rx_rd_data)
    );

    // Request decode: everything works off the state before the request,
    // so completion sees the armed flag as it was before the event.
    always_comb begin
        n_send_enable    = r_send_enable;
        n_complete_armed = r_complete_armed;
        n_tx_busy        = r_tx_busy;
        n_notify_pending = r_notify_pending;
        n_err            = r_err;
        n_send_valid     = 1'b0;
        n_rx_notify      = 1'b0;
        n_tx_notify      = 1'b0;
        n_put_acc        = 1'b0;
        n_get_valid      = 1'b0;
        n_still          = 1'b0;
        tx_push          = 1'b0;
        tx_pop           = 1'b0;
        rx_push          = 1'b0;
        rx_pop           = 1'b0;
        flush            = 1'b0;
        err_rx           = 1'b0;
        send_try         = 1'b0;

        if (in_fire) begin
            case (urbc_pkg::t_mode'(i_mode))
                urbc_pkg::MODE_LINE: begin
                    // received byte: bad or ring full drops it and counts
                    err_rx  = i_rx_ready && (i_rx_bad || rx_stat.full);
                    rx_push = i_rx_ready && !i_rx_bad && !rx_stat.full;
                    if (rx_push && r_rx_en && !r_notify_pending) begin
                        n_notify_pending = 1'b1;
                        n_rx_notify      = 1'b1;
                    end
                    n_err = r_err + urbc_pkg::ERR_W'(err_rx)
                                  + urbc_pkg::ERR_W'(i_line_overrun);
                    // transmit slot
                    send_try = i_tx_slot_free && r_send_enable;
                    if (send_try) begin
                        if (!tx_stat.empty) begin
                            tx_pop       = 1'b1;
                            n_send_valid = 1'b1;
                        end else begin
                            n_send_enable    = 1'b0;
                            n_complete_armed = 1'b1;
                        end
                    end
                    // completion armed before this event
                    if (i_tx_finished && r_complete_armed) begin
                        n_complete_armed = 1'b0;
                        n_tx_busy        = 1'b0;
                        n_tx_notify      = r_tx_en;
                    end
                end
                urbc_pkg::MODE_PUT: begin
                    if (!tx_stat.full) begin
                        tx_push       = 1'b1;
                        n_tx_busy     = 1'b1;
                        n_send_enable = 1'b1;
                        n_put_acc     = 1'b1;
                    end
                end
                urbc_pkg::MODE_GET: begin
                    rx_pop      = !rx_stat.empty;
                    n_get_valid = !rx_stat.empty;
                end
                urbc_pkg::MODE_FINISH: begin
                    n_still = !rx_stat.empty;
                    if (rx_stat.empty) begin
                        n_notify_pending = 1'b0;
                    end
                end
                urbc_pkg::MODE_FLUSH: begin
                    flush            = 1'b1;
                    n_tx_busy        = 1'b0;
                    n_notify_pending = 1'b0;
                end
                default: begin
                    // unused codes: status only
                end
            endcase
        end

        // writing the receive enable drops the pending mark
        if (i_cfg_valid && o_cfg_ready && (i_cfg_index == urbc_pkg::CFG_RX_NOTIFY_EN)) begin
            n_notify_pending = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_send_enable    <= 1'b0;
            r_complete_armed <= 1'b0;
            r_tx_busy        <= 1'b0;
            r_notify_pending <= 1'b0;
            r_err            <= '0;
            r_rx_en          <= 1'b0;
            r_tx_en          <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            r_send_enable    <= n_send_enable;
            r_complete_armed <= n_complete_armed;
            r_tx_busy        <= n_tx_busy;
            r_err            <= n_err;
            r_notify_pending <= n_notify_pending;
            // config must only arrive while idle; the block does not enforce it
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    urbc_pkg::CFG_RX_NOTIFY_EN: begin
                        r_rx_en <= i_cfg_data;
                    end
                    urbc_pkg::CFG_TX_NOTIFY_EN: begin
                        r_tx_en <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_send_valid <= n_send_valid;
            r_rx_notify  <= n_rx_notify;
            r_tx_notify  <= n_tx_notify;
            r_put_acc    <= n_put_acc;
            r_get_valid  <= n_get_valid;
            r_still      <= n_still;
        end
    end

    // Status fields read live state: it only moves on an accepted request,
    // which happens only as the previous result leaves or when none is waiting.
    assign o_out_valid        = r_out_valid;
    assign o_send_valid       = r_send_valid;
    assign o_send_byte        = r_send_valid ? tx_rd_data : '0;
    assign o_rx_notify        = r_rx_notify;
    assign o_tx_notify        = r_tx_notify;
    assign o_put_accepted     = r_put_acc;
    assign o_get_valid        = r_get_valid;
    assign o_get_byte         = r_get_valid ? rx_rd_data : '0;
    assign o_rx_still_pending = r_still;
    assign o_error_total      = r_err;
    assign o_rx_fill          = urbc_pkg::BYTE_W'(rx_fill);
    assign o_tx_idle          = (tx_fill == '0) && !r_tx_busy;

`ifndef NO_ASSERTIONS
    // a flush leaves both rings empty
    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_mode == urbc_pkg::MODE_FLUSH) |=> (rx_stat.empty && tx_stat.empty))
        else $error("rings not empty after flush");

    // receive fill only moves on an accepted request
    a_fill_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_fire |=> $stable(rx_fill))
        else $error("receive fill moved without a request");

    // at most two errors per request
    a_err_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (urbc_pkg::ERR_W'(r_err - $past(r_err)) <= 16'd2))
        else $error("error count jumped");

    // a sent byte only comes from a line event with sending enabled
    a_send_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tx_pop |-> (r_send_enable && !tx_stat.empty))
        else $error("transmit pop while disabled or empty");
`endif

endmodule
